// ===== sv/hhq_pkg.sv =====
// Package for the heightmap height query unit: widths, formats, register codes
// and the struct types shared by the front end, the queue and the back end.
// No dependencies.
`timescale 1ns / 1ps

package hhq_pkg;

   // Grid limits and fixed-point format
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_LENGTH = 256;
   localparam int FRAC_BITS  = 8;

   // Field widths
   localparam int POS_BITS  = 24;
   localparam int INV_BITS  = 24;
   localparam int GAIN_BITS = 16;
   localparam int DIM_BITS  = 9;
   localparam int HGT_BITS  = 8;
   localparam int IDX_BITS  = 16;
   localparam int OUT_BITS  = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   // Grid coordinate = (distance * reciprocal) >> GRID_SHIFT
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_LENGTH);
   localparam int PROD_BITS  = POS_BITS + INV_BITS;
   localparam int GRID_SHIFT = INV_BITS - FRAC_BITS;
   localparam int GRID_BITS  = PROD_BITS - GRID_SHIFT;
   localparam int STORE_SIZE = MAX_WIDTH * MAX_LENGTH;

   // Interpolation widths (signed)
   localparam int ONE          = 1 << FRAC_BITS;
   localparam int WGT_BITS     = FRAC_BITS + 2;
   localparam int CORNER_BITS  = HGT_BITS + 3;
   localparam int LERP1_BITS   = CORNER_BITS + WGT_BITS;
   localparam int LERP2_BITS   = LERP1_BITS + WGT_BITS + 1;
   localparam int HPROD_BITS   = LERP2_BITS - 1 + GAIN_BITS;
   localparam int SCALE_SHIFT  = 2 * FRAC_BITS - 8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Item kinds
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_WORLD_EXTENT = 3'd0,
      REG_INV_CELL_X   = 3'd1,
      REG_INV_CELL_Z   = 3'd2,
      REG_HEIGHT_GAIN  = 3'd3,
      REG_GRID_WIDTH   = 3'd4,
      REG_GRID_LENGTH  = 3'd5
   } csr_reg_type;

   // Configuration bundle
   typedef struct packed {
      logic [POS_BITS-1:0]  world_extent;
      logic [INV_BITS-1:0]  inv_cell_x;
      logic [INV_BITS-1:0]  inv_cell_z;
      logic [GAIN_BITS-1:0] height_gain;
      logic [DIM_BITS-1:0]  grid_width;
      logic [DIM_BITS-1:0]  grid_length;
   } cfg_type;

   // Classified item as held in the queue
   typedef struct packed {
      logic                func;
      logic                neg;
      logic [IDX_BITS-1:0] entry_index;
      logic [HGT_BITS-1:0] entry_height;
      logic [POS_BITS-1:0] dist_x;
      logic [POS_BITS-1:0] dist_z;
   } item_type;

endpackage

// ===== sv/heightmap_height_query_unit.sv =====
// Heightmap height query unit: 256 x 256 height store, triangle interpolation.
// A request passes through the queue, stages 1 to 6 and the output register to rsp_tvalid.
// Throughput: one item per cycle, set by the four-corner read from two dual-read
// store copies; a held response stalls the back pipeline, the 4-entry queue absorbs.
// Reset clears control and configuration; the height store is not cleared.
// Depends on hhq_pkg, hhq_front, hhq_queue, hhq_back.
`timescale 1ns / 1ps

module heightmap_height_query_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [71:0]                         req_tdata,  // entry_index, entry_height, pos_x, pos_z
   input  logic                                req_tuser,  // func
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hhq_pkg::OUT_BITS-1:0]        rsp_tdata,  // height_out
   output logic                                rsp_tuser,  // outside
   // configuration write port
   input  logic                                csr_we,
   input  logic [hhq_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [hhq_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import hhq_pkg::*;

   cfg_type  cfg_ff;
   item_type push_item, pop_item;
   logic     q_push, q_pop, q_empty, q_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.world_extent <= POS_BITS'(65536);
         cfg_ff.inv_cell_x   <= INV_BITS'(65536);
         cfg_ff.inv_cell_z   <= INV_BITS'(65536);
         cfg_ff.height_gain  <= GAIN_BITS'(256);
         cfg_ff.grid_width   <= DIM_BITS'(256);
         cfg_ff.grid_length  <= DIM_BITS'(256);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WORLD_EXTENT: cfg_ff.world_extent <= csr_wdata[POS_BITS-1:0];
            REG_INV_CELL_X:   cfg_ff.inv_cell_x   <= csr_wdata[INV_BITS-1:0];
            REG_INV_CELL_Z:   cfg_ff.inv_cell_z   <= csr_wdata[INV_BITS-1:0];
            REG_HEIGHT_GAIN:  cfg_ff.height_gain  <= csr_wdata[GAIN_BITS-1:0];
            REG_GRID_WIDTH:   cfg_ff.grid_width   <= csr_wdata[DIM_BITS-1:0];
            REG_GRID_LENGTH:  cfg_ff.grid_length  <= csr_wdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   hhq_front u_front (
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_func         (req_tuser),
      .req_entry_index  (req_tdata[15:0]),
      .req_entry_height (req_tdata[23:16]),
      .req_pos_x        (req_tdata[47:24]),
      .req_pos_z        (req_tdata[71:48]),
      .cfg              (cfg_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (push_item)
   );

   hhq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   hhq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_height_out (rsp_tdata),
      .rsp_outside    (rsp_tuser)
   );

endmodule

// ===== sv/hhq_front.sv =====
// Front end of the height query unit: accepts request transfers, mirrors the
// query position against the world extent and flags negative distances.
// Depends on hhq_pkg.
`timescale 1ns / 1ps

module hhq_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_func,
   input  logic [hhq_pkg::IDX_BITS-1:0]  req_entry_index,
   input  logic [hhq_pkg::HGT_BITS-1:0]  req_entry_height,
   input  logic [hhq_pkg::POS_BITS-1:0]  req_pos_x,
   input  logic [hhq_pkg::POS_BITS-1:0]  req_pos_z,
   input  hhq_pkg::cfg_type              cfg,
   input  logic                          q_full,
   output logic                          q_push,
   output hhq_pkg::item_type             q_item
);
   import hhq_pkg::*;

   // Take a transfer whenever the queue has room
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Mirror against the extent; a position past the extent is outside
   always_comb begin
      q_item.func         = req_func;
      q_item.entry_index  = req_entry_index;
      q_item.entry_height = req_entry_height;
      q_item.dist_x       = cfg.world_extent - req_pos_x;
      q_item.dist_z       = cfg.world_extent - req_pos_z;
      q_item.neg          = (req_pos_x > cfg.world_extent) ||
                            (req_pos_z > cfg.world_extent);
   end

endmodule

// ===== sv/hhq_queue.sv =====
// Short FIFO that decouples the front end from the back-end pipeline.
// Depends on hhq_pkg.
`timescale 1ns / 1ps

module hhq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hhq_pkg::item_type push_item,
   input  logic              pop,
   output hhq_pkg::item_type pop_item,
   output logic              empty,
   output logic              full
);
   import hhq_pkg::*;

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign pop_item = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/hhq_back.sv =====
// Back end of the height query unit: grid coordinate scaling, corner address
// generation, height store, triangle interpolation and gain. Depends on hhq_pkg.
`timescale 1ns / 1ps

module hhq_back (
   input  logic                          clock,
   input  logic                          reset,
   input  hhq_pkg::cfg_type              cfg,
   input  logic                          q_empty,
   input  hhq_pkg::item_type             q_item,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [hhq_pkg::OUT_BITS-1:0]  rsp_height_out,
   output logic                          rsp_outside
);
   import hhq_pkg::*;

   logic en;

   // Stage 1: scale distances into grid coordinates
   logic                   s1_valid_ff, s1_func_ff, s1_neg_ff;
   logic [IDX_BITS-1:0]    s1_idx_ff;
   logic [HGT_BITS-1:0]    s1_hgt_ff;
   logic [GRID_BITS-1:0]   s1_gx_ff, s1_gz_ff;
   logic [PROD_BITS-1:0]   prod_x, prod_z;

   // Stage 2: cell, fraction, clamped neighbors, row bases
   logic                   s2_valid_ff, s2_func_ff, s2_outside_ff;
   logic [IDX_BITS-1:0]    s2_idx_ff;
   logic [HGT_BITS-1:0]    s2_hgt_ff;
   logic [COL_BITS-1:0]    s2_cx_ff, s2_cx1_ff;
   logic [FRAC_BITS-1:0]   s2_fx_ff, s2_fz_ff;
   logic [IDX_BITS-1:0]    s2_rb0_ff, s2_rb1_ff;
   logic [DIM_BITS-1:0]    w_eff, l_eff;
   logic [COL_BITS-1:0]    cx, cx1_in;
   logic [ROW_BITS-1:0]    cz, cz1;
   logic [DIM_BITS-1:0]    cx_next, cz_next;
   logic                   out_x, out_z, outside_in;
   logic [ROW_BITS+DIM_BITS-1:0] rb0_full, rb1_full;

   // Stage 3: store access
   logic [HGT_BITS-1:0]    store_lo_mem [STORE_SIZE];
   logic [HGT_BITS-1:0]    store_hi_mem [STORE_SIZE];
   logic                   s3_valid_ff, s3_func_ff, s3_outside_ff;
   logic [FRAC_BITS-1:0]   s3_fx_ff, s3_fz_ff;
   logic [HGT_BITS-1:0]    s3_bl_ff, s3_br_ff, s3_tl_ff, s3_tr_ff;
   logic [IDX_BITS-1:0]    addr_bl, addr_br, addr_tl, addr_tr;

   // Stage 4: diagonal fix-up and lerps along X
   logic                          s4_valid_ff, s4_func_ff, s4_outside_ff;
   logic [FRAC_BITS-1:0]          s4_fz_ff;
   logic signed [LERP1_BITS-1:0]  s4_top_ff, s4_bot_ff, top_in, bot_in;
   logic signed [CORNER_BITS-1:0] c_bl, c_br, c_tl, c_tr, fix_bl, fix_tr;
   logic signed [WGT_BITS-1:0]    wx, wx1;
   logic [FRAC_BITS:0]            frac_sum;

   // Stage 5: lerp along Z
   logic                          s5_valid_ff, s5_func_ff, s5_outside_ff;
   logic signed [LERP2_BITS-1:0]  s5_h_ff, h_in;
   logic signed [WGT_BITS-1:0]    wz, wz1;

   // Stage 6: gain
   logic                          s6_valid_ff, s6_func_ff, s6_outside_ff;
   logic [HPROD_BITS-1:0]         s6_prod_ff, prod_in;
   logic [LERP2_BITS-2:0]         h_clamp;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_outside_ff;
   logic [OUT_BITS-1:0]           rsp_height_ff, height_in;

   // Whole pipeline moves unless a result is held at the output
   assign en    = !rsp_valid_ff || rsp_tready;
   assign q_pop = en && !q_empty;

   // ---- Stage 1 ----
   assign prod_x = PROD_BITS'(q_item.dist_x) * PROD_BITS'(cfg.inv_cell_x);
   assign prod_z = PROD_BITS'(q_item.dist_z) * PROD_BITS'(cfg.inv_cell_z);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_func_ff <= q_item.func;
         s1_neg_ff  <= q_item.neg;
         s1_idx_ff  <= q_item.entry_index;
         s1_hgt_ff  <= q_item.entry_height;
         s1_gx_ff   <= prod_x[PROD_BITS-1:GRID_SHIFT];
         s1_gz_ff   <= prod_z[PROD_BITS-1:GRID_SHIFT];
      end
   end

   // ---- Stage 2 ----
   always_comb begin
      w_eff = (cfg.grid_width  > DIM_BITS'(MAX_WIDTH))  ? DIM_BITS'(MAX_WIDTH)  : cfg.grid_width;
      l_eff = (cfg.grid_length > DIM_BITS'(MAX_LENGTH)) ? DIM_BITS'(MAX_LENGTH) : cfg.grid_length;
      cx    = s1_gx_ff[FRAC_BITS+COL_BITS-1:FRAC_BITS];
      cz    = s1_gz_ff[FRAC_BITS+ROW_BITS-1:FRAC_BITS];
      out_x = (|s1_gx_ff[GRID_BITS-1:FRAC_BITS+COL_BITS]) ||
              (DIM_BITS'(cx) >= w_eff);
      out_z = (|s1_gz_ff[GRID_BITS-1:FRAC_BITS+ROW_BITS]) ||
              (DIM_BITS'(cz) >= l_eff);
      outside_in = s1_neg_ff || out_x || out_z;
      // neighbor column and row, clamped to the last one in use
      cx_next = DIM_BITS'(cx) + 1'b1;
      cz_next = DIM_BITS'(cz) + 1'b1;
      cx1_in  = (cx_next < w_eff) ? cx_next[COL_BITS-1:0] : COL_BITS'(w_eff - 1'b1);
      cz1     = (cz_next < l_eff) ? cz_next[ROW_BITS-1:0] : ROW_BITS'(l_eff - 1'b1);
      rb0_full = (ROW_BITS+DIM_BITS)'(cz)  * (ROW_BITS+DIM_BITS)'(w_eff);
      rb1_full = (ROW_BITS+DIM_BITS)'(cz1) * (ROW_BITS+DIM_BITS)'(w_eff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_func_ff    <= s1_func_ff;
         s2_outside_ff <= outside_in;
         s2_idx_ff     <= s1_idx_ff;
         s2_hgt_ff     <= s1_hgt_ff;
         s2_cx_ff      <= cx;
         s2_cx1_ff     <= cx1_in;
         s2_fx_ff      <= s1_gx_ff[FRAC_BITS-1:0];
         s2_fz_ff      <= s1_gz_ff[FRAC_BITS-1:0];
         s2_rb0_ff     <= rb0_full[IDX_BITS-1:0];
         s2_rb1_ff     <= rb1_full[IDX_BITS-1:0];
      end
   end

   // ---- Stage 3: two store copies, two read ports each ----
   assign addr_bl = s2_rb0_ff + IDX_BITS'(s2_cx_ff);
   assign addr_br = s2_rb0_ff + IDX_BITS'(s2_cx1_ff);
   assign addr_tl = s2_rb1_ff + IDX_BITS'(s2_cx_ff);
   assign addr_tr = s2_rb1_ff + IDX_BITS'(s2_cx1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         if (s2_valid_ff && (s2_func_ff == FUNC_WRITE)) begin
            store_lo_mem[s2_idx_ff] <= s2_hgt_ff;
            store_hi_mem[s2_idx_ff] <= s2_hgt_ff;
         end
         s3_bl_ff <= store_lo_mem[addr_bl];
         s3_br_ff <= store_lo_mem[addr_br];
         s3_tl_ff <= store_hi_mem[addr_tl];
         s3_tr_ff <= store_hi_mem[addr_tr];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_func_ff    <= s2_func_ff;
         s3_outside_ff <= s2_outside_ff;
         s3_fx_ff      <= s2_fx_ff;
         s3_fz_ff      <= s2_fz_ff;
      end
   end

   // ---- Stage 4: replace the corner off the diagonal, lerp along X ----
   always_comb begin
      c_bl = signed'(CORNER_BITS'(s3_bl_ff));
      c_br = signed'(CORNER_BITS'(s3_br_ff));
      c_tl = signed'(CORNER_BITS'(s3_tl_ff));
      c_tr = signed'(CORNER_BITS'(s3_tr_ff));
      frac_sum = (FRAC_BITS+1)'(s3_fx_ff) + (FRAC_BITS+1)'(s3_fz_ff);
      fix_bl = c_bl;
      fix_tr = c_tr;
      if (frac_sum < (FRAC_BITS+1)'(ONE)) begin
         fix_tr = c_tl + c_br - c_bl;
      end else begin
         fix_bl = c_tl + c_br - c_tr;
      end
      wx  = signed'(WGT_BITS'(s3_fx_ff));
      wx1 = signed'(WGT_BITS'(ONE) - WGT_BITS'(s3_fx_ff));
      top_in = LERP1_BITS'(c_tl) * LERP1_BITS'(wx1) +
               LERP1_BITS'(fix_tr) * LERP1_BITS'(wx);
      bot_in = LERP1_BITS'(fix_bl) * LERP1_BITS'(wx1) +
               LERP1_BITS'(c_br) * LERP1_BITS'(wx);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_func_ff    <= s3_func_ff;
         s4_outside_ff <= s3_outside_ff;
         s4_fz_ff      <= s3_fz_ff;
         s4_top_ff     <= top_in;
         s4_bot_ff     <= bot_in;
      end
   end

   // ---- Stage 5: lerp along Z ----
   always_comb begin
      wz   = signed'(WGT_BITS'(s4_fz_ff));
      wz1  = signed'(WGT_BITS'(ONE) - WGT_BITS'(s4_fz_ff));
      h_in = LERP2_BITS'(s4_bot_ff) * LERP2_BITS'(wz1) +
             LERP2_BITS'(s4_top_ff) * LERP2_BITS'(wz);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_func_ff    <= s4_func_ff;
         s5_outside_ff <= s4_outside_ff;
         s5_h_ff       <= h_in;
      end
   end

   // ---- Stage 6: clamp below zero, apply gain ----
   always_comb begin
      h_clamp = s5_h_ff[LERP2_BITS-1] ? '0 : s5_h_ff[LERP2_BITS-2:0];
      prod_in = HPROD_BITS'(h_clamp) * HPROD_BITS'(cfg.height_gain);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_func_ff    <= s5_func_ff;
         s6_outside_ff <= s5_outside_ff;
         s6_prod_ff    <= prod_in;
      end
   end

   // ---- Output: rescale, saturate, zero when outside ----
   always_comb begin
      rsp_valid_in = s6_valid_ff && (s6_func_ff == FUNC_QUERY);
      if (s6_outside_ff) begin
         height_in = '0;
      end else if (|s6_prod_ff[HPROD_BITS-1:SCALE_SHIFT+OUT_BITS]) begin
         height_in = '1;
      end else begin
         height_in = s6_prod_ff[SCALE_SHIFT+OUT_BITS-1:SCALE_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_outside_ff <= s6_outside_ff;
         rsp_height_ff  <= height_in;
      end
   end

   // Valid bits of all stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= q_pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_height_out = rsp_height_ff;
   assign rsp_outside    = rsp_outside_ff;

   // Outside results carry a zero height
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_outside_ff |-> rsp_height_ff == '0)
      else $error("outside result with nonzero height");

   // A store write never turns into a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      en && s6_valid_ff && (s6_func_ff == FUNC_WRITE) |=> !rsp_valid_ff)
      else $error("write item produced a response");

   // Every item taken from the queue enters stage 1
   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> s1_valid_ff)
      else $error("popped item lost before stage 1");

   // The pipeline moves only when the output register can take a result
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> s6_valid_ff == $past(s6_valid_ff))
      else $error("pipeline advanced while output was held");

endmodule

// ===== tb/sv/tb_heightmap_height_query_unit.sv =====
// Self-checking testbench for heightmap_height_query_unit: a directed table, then
// randomized write/query traffic over several register settings, with a local predictor.
// Depends on hhq_pkg and heightmap_height_query_unit.
`timescale 1ns / 1ps

module tb_heightmap_height_query_unit;
   import hhq_pkg::*;

   localparam int ITEMS_PER_PHASE = 235;
   localparam int NUM_PHASES      = 8;
   localparam int DRAIN_CYCLES    = 16;   // pipeline and queue depth, with margin
   localparam int LONG_HOLD       = 80;
   localparam int HOLD_AT_RESULT  = 150;
   localparam int HOLD_MIN_OPEN   = 4;    // queries in flight before the long stall starts
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 30;
   localparam int DIRECTED_COUNT  = 20;

   // One expected response
   typedef struct packed {
      logic [OUT_BITS-1:0] height;
      logic                outside;
   } height_result_type;

   // One row of the directed table; typed rows carry their own expected response
   typedef struct packed {
      logic                func;
      logic [IDX_BITS-1:0] idx;
      logic [HGT_BITS-1:0] hgt;
      logic [POS_BITS-1:0] px;
      logic [POS_BITS-1:0] pz;
      bit                  typed;
      logic [OUT_BITS-1:0] exp_height;
      logic                exp_outside;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [71:0]              req_tdata = '0;   // entry_index, entry_height, pos_x, pos_z
   logic                     req_tuser = 1'b0; // func
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [OUT_BITS-1:0]      rsp_tdata;        // height_out
   logic                     rsp_tuser;        // outside
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   heightmap_height_query_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: register copy, height grid and which entries hold data
   cfg_type             grid_cfg;
   logic [HGT_BITS-1:0] height_mem  [0:STORE_SIZE-1];
   bit                  written_mem [0:STORE_SIZE-1];
   height_result_type   pending_heights [$];

   bit quiet = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_left = 0;
   int error_count = 0;
   int report_count = 0;
   int items_sent = 0;
   int writes_sent = 0;
   int queries_inside = 0;
   int queries_outside = 0;
   int results_checked = 0;
   int settings_loaded = 0;
   height_result_type rsp_want;

   // Directed table; reset settings give cell = distance >> 8, fraction = distance & 255
   stim_row_type directed_rows [0:DIRECTED_COUNT-1] = '{
      '{FUNC_WRITE, 16'd0,     8'd100, 24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      '{FUNC_WRITE, 16'd1,     8'd200, 24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      '{FUNC_WRITE, 16'd256,   8'd50,  24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      '{FUNC_WRITE, 16'd257,   8'd20,  24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      // zero distance: exactly the first corner
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd65536,  24'd65536,  1'b1, 32'h0064_0000, 1'b0},
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd65408,  24'd65536,  1'b0, 32'd0, 1'b0},
      // fractions summing past one, then under one: both triangles
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd65344,  24'd65344,  1'b0, 32'd0, 1'b0},
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd65436,  24'd65486,  1'b0, 32'd0, 1'b0},
      '{FUNC_WRITE, 16'hFFFF,  8'hFF,  24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      // last cell on both axes: all corners clamp to the last entry
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd128,    24'd128,    1'b1, 32'h00FF_0000, 1'b0},
      '{FUNC_WRITE, 16'd255,   8'd0,   24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      '{FUNC_WRITE, 16'd511,   8'hFF,  24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd1,      24'd65472,  1'b0, 32'd0, 1'b0},
      // negative distance, past the last row, all ones, past the last column
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd65537,  24'd65536,  1'b1, 32'd0, 1'b1},
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd65536,  24'd0,      1'b1, 32'd0, 1'b1},
      '{FUNC_QUERY, 16'hFFFF,  8'hFF,  24'hFFFFFF, 24'hFFFFFF, 1'b1, 32'd0, 1'b1},
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd0,      24'd0,      1'b1, 32'd0, 1'b1},
      // overwrite the last entry and read it back
      '{FUNC_WRITE, 16'hFFFF,  8'd0,   24'd0,      24'd0,      1'b0, 32'd0, 1'b0},
      '{FUNC_QUERY, 16'd0,     8'd0,   24'd128,    24'd128,    1'b1, 32'd0, 1'b0},
      '{FUNC_WRITE, 16'hAAAA,  8'hA5,  24'h555555, 24'hAAAAAA, 1'b0, 32'd0, 1'b0}
   };

   function automatic int unsigned eff_dim(input logic [DIM_BITS-1:0] r,
                                           input int unsigned limit);
      return (r > limit) ? limit : r;
   endfunction

   // Mirror one axis and scale to grid units; 0 when this axis is off the grid
   function automatic bit grid_axis(input logic [POS_BITS-1:0] pos,
                                    input logic [INV_BITS-1:0] inv,
                                    input int unsigned dim,
                                    output int unsigned coord,
                                    output int unsigned coord1,
                                    output int frac);
      longint unsigned g;
      coord  = 0;
      coord1 = 0;
      frac   = 0;
      if (pos > grid_cfg.world_extent) return 1'b0;
      g = ((64'(grid_cfg.world_extent) - 64'(pos)) * 64'(inv)) >> GRID_SHIFT;
      if ((g >> FRAC_BITS) >= 64'(dim)) return 1'b0;
      coord  = int'(g >> FRAC_BITS);
      frac   = int'(g & 64'(ONE - 1));
      coord1 = (coord + 1 < dim) ? coord + 1 : dim - 1;
      return 1'b1;
   endfunction

   // Store indexes of the four corners around a point; 0 when the point is off the grid
   function automatic bit locate_cell(input logic [POS_BITS-1:0] px,
                                      input logic [POS_BITS-1:0] pz,
                                      output int unsigned bl_i, output int unsigned br_i,
                                      output int unsigned tl_i, output int unsigned tr_i,
                                      output int fx, output int fz);
      int unsigned w, l, cx, cx1, cz, cz1;
      bit in_x, in_z;
      w    = eff_dim(grid_cfg.grid_width, MAX_WIDTH);
      l    = eff_dim(grid_cfg.grid_length, MAX_LENGTH);
      in_x = grid_axis(px, grid_cfg.inv_cell_x, w, cx, cx1, fx);
      in_z = grid_axis(pz, grid_cfg.inv_cell_z, l, cz, cz1, fz);
      bl_i = cx + cz * w;
      br_i = cx1 + cz * w;
      tl_i = cx + cz1 * w;
      tr_i = cx1 + cz1 * w;
      return in_x && in_z;
   endfunction

   // Triangle interpolation and gain
   function automatic height_result_type interp_height(input logic [POS_BITS-1:0] px,
                                                       input logic [POS_BITS-1:0] pz);
      height_result_type r;
      int unsigned bl_i, br_i, tl_i, tr_i;
      int fx, fz;
      longint wx, wz, bl, br, tl, tr, top, bot, h;
      longint unsigned scaled;
      r.height  = '0;
      r.outside = 1'b1;
      if (!locate_cell(px, pz, bl_i, br_i, tl_i, tr_i, fx, fz)) return r;
      wx = fx;
      wz = fz;
      bl = height_mem[bl_i];
      br = height_mem[br_i];
      tl = height_mem[tl_i];
      tr = height_mem[tr_i];
      // replace the corner across the diagonal by the plane through the other three
      if (wx + wz < ONE) tr = tl + (br - bl);
      else bl = tl + (br - tr);
      top = tl * (ONE - wx) + tr * wx;
      bot = bl * (ONE - wx) + br * wx;
      h   = bot * (ONE - wz) + top * wz;
      if (h < 0) h = 0;
      scaled = (64'(h) * 64'(grid_cfg.height_gain)) >> SCALE_SHIFT;
      if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
      r.height  = scaled[OUT_BITS-1:0];
      r.outside = 1'b0;
      return r;
   endfunction

   // Position whose mirrored distance lands on the grid, or on its border at_edge
   function automatic logic [POS_BITS-1:0] pick_pos(input logic [INV_BITS-1:0] inv,
                                                    input int unsigned dim,
                                                    input bit at_edge);
      longint unsigned span;
      if (dim == 0) return POS_BITS'($urandom);
      if (inv == 0) span = grid_cfg.world_extent;
      else begin
         span = ((64'(dim) << (FRAC_BITS + GRID_SHIFT)) - 1) / 64'(inv);
         if (span > 64'(grid_cfg.world_extent)) span = grid_cfg.world_extent;
      end
      if (!at_edge)
         return grid_cfg.world_extent - POS_BITS'($urandom_range(0, 32'(span)));
      case ($urandom_range(0, 2))
         0: return grid_cfg.world_extent;
         1: return grid_cfg.world_extent - POS_BITS'(span);
         default: return grid_cfg.world_extent + 1'b1;
      endcase
   endfunction

   // Offer one item until it transfers, then update the predictor
   task automatic send_item(input logic func, input logic [IDX_BITS-1:0] idx,
                            input logic [HGT_BITS-1:0] hgt,
                            input logic [POS_BITS-1:0] px, input logic [POS_BITS-1:0] pz,
                            input bit typed, input logic [OUT_BITS-1:0] exp_height,
                            input logic exp_outside);
      height_result_type want;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {pz, px, hgt, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (func == FUNC_WRITE) begin
         height_mem[idx]  = hgt;
         written_mem[idx] = 1'b1;
         writes_sent++;
      end else begin
         if (typed) begin
            want.height  = exp_height;
            want.outside = exp_outside;
         end else
            want = interp_height(px, pz);
         if (want.outside) queries_outside++;
         else queries_inside++;
         pending_heights = {pending_heights, want};
      end
   endtask

   // Query that first fills any corner not yet written
   task automatic query_with_corners(input logic [POS_BITS-1:0] px,
                                     input logic [POS_BITS-1:0] pz);
      int unsigned corners [4];
      int fx, fz;
      if (locate_cell(px, pz, corners[0], corners[1], corners[2], corners[3], fx, fz))
         foreach (corners[k])
            if (!written_mem[corners[k]])
               send_item(FUNC_WRITE, IDX_BITS'(corners[k]), HGT_BITS'($urandom),
                         POS_BITS'($urandom), POS_BITS'($urandom), 1'b0, '0, 1'b0);
      send_item(FUNC_QUERY, IDX_BITS'($urandom), HGT_BITS'($urandom), px, pz,
                1'b0, '0, 1'b0);
   endtask

   task automatic csr_write(input csr_reg_type sel, input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Load a register set once the block has drained; unused high bits carry noise
   task automatic load_settings(input cfg_type s);
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(REG_WORLD_EXTENT, s.world_extent);
      csr_write(REG_INV_CELL_X, s.inv_cell_x);
      csr_write(REG_INV_CELL_Z, s.inv_cell_z);
      csr_write(REG_HEIGHT_GAIN, {8'($urandom), s.height_gain});
      csr_write(REG_GRID_WIDTH, {15'($urandom), s.grid_width});
      csr_write(REG_GRID_LENGTH, {15'($urandom), s.grid_length});
      csr_we   <= 1'b0;
      grid_cfg = s;
      settings_loaded++;
   endtask

   // Response side: check each transfer, stall in short bursts and once for a long stretch
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_heights.size() == 0) begin
            error_count++;
            if (report_count++ < MAX_REPORTS)
               $display("%0t: unexpected response, expected none, got height %h outside %b",
                        $time, rsp_tdata, rsp_tuser);
         end else begin
            rsp_want = pending_heights.pop_front();
            results_checked++;
            if (rsp_want.height !== rsp_tdata) begin
               error_count++;
               if (report_count++ < MAX_REPORTS)
                  $display("%0t: height_out mismatch, expected %h, got %h",
                           $time, rsp_want.height, rsp_tdata);
            end
            if (rsp_want.outside !== rsp_tuser) begin
               error_count++;
               if (report_count++ < MAX_REPORTS)
                  $display("%0t: outside mismatch, expected %b, got %b",
                           $time, rsp_want.outside, rsp_tuser);
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && !quiet && results_checked >= HOLD_AT_RESULT &&
                   pending_heights.size() >= HOLD_MIN_OPEN) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   // Watchdog: too many cycles without any transfer
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
               $time, WATCHDOG_LIMIT, pending_heights.size());
      $display("CHECK FAILED");
      $finish;
   end

   // Main sequence
   initial begin
      cfg_type s;
      int start_items;
      int unsigned pick;
      int unsigned wdim, ldim;

      grid_cfg.world_extent = 24'd65536;
      grid_cfg.inv_cell_x   = 24'd65536;
      grid_cfg.inv_cell_z   = 24'd65536;
      grid_cfg.height_gain  = 16'd256;
      grid_cfg.grid_width   = 9'd256;
      grid_cfg.grid_length  = 9'd256;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset settings
      foreach (directed_rows[n])
         send_item(directed_rows[n].func, directed_rows[n].idx, directed_rows[n].hgt,
                   directed_rows[n].px, directed_rows[n].pz, directed_rows[n].typed,
                   directed_rows[n].exp_height, directed_rows[n].exp_outside);

      // random part, one register setting per phase, extremes first
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: s = '{24'd4096, 24'h100000, 24'h080000, 16'hFFFF, 9'd16, 9'd16};
            1: s = '{24'hFFFFFF, 24'd1, 24'hFFFFFF, 16'd0, 9'd2, 9'd2};
            2: s = '{24'd0, 24'd0, 24'd0, 16'd1, 9'd256, 9'd256};
            // zero width puts every point off the grid; oversized length saturates
            3: s = '{24'h00C000, 24'h00C000, 24'h018000, 16'h0180, 9'd0, 9'd300};
            4: s = '{24'h020000, 24'h010000, 24'h008000, 16'h0100, 9'd511, 9'd3};
            NUM_PHASES - 1: s = '{24'h010000, 24'h010000, 24'h010000, 16'h0100,
                                  9'd256, 9'd256};
            default: s = '{24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom),
                           24'($urandom), 16'($urandom), 9'($urandom_range(2, 256)),
                           9'($urandom_range(2, 256))};
         endcase
         req_tvalid <= 1'b0;
         load_settings(s);
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         wdim = eff_dim(grid_cfg.grid_width, MAX_WIDTH);
         ldim = eff_dim(grid_cfg.grid_length, MAX_LENGTH);
         start_items = items_sent;
         while (items_sent - start_items < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
               query_with_corners(pick_pos(grid_cfg.inv_cell_x, wdim, 1'b0),
                                  pick_pos(grid_cfg.inv_cell_z, ldim, 1'b0));
            else if (pick < 77)
               query_with_corners(POS_BITS'($urandom), POS_BITS'($urandom));
            else if (pick < 92)
               send_item(FUNC_WRITE, IDX_BITS'($urandom), HGT_BITS'($urandom),
                         POS_BITS'($urandom), POS_BITS'($urandom), 1'b0, '0, 1'b0);
            else
               query_with_corners(pick_pos(grid_cfg.inv_cell_x, wdim, 1'b1),
                                  pick_pos(grid_cfg.inv_cell_z, ldim, 1'b1));
         end
      end
      req_tvalid <= 1'b0;

      while (pending_heights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d height writes, %0d queries on the grid, %0d off it.",
               items_sent, writes_sent, queries_inside, queries_outside);
      $display("Compared %0d responses across %0d register loads, one %0d-cycle receiver stall.",
               results_checked, settings_loaded, LONG_HOLD);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
